// ===== hdl/gvd_pkg.sv =====
// Package for the group varint decoder: command codes passed from the
// front to the back, queue sizing, status codes and size decode.
// No dependencies.
`timescale 1ns / 1ps

package gvd_pkg;

   // Result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_TRUNC = 1'b1;

   // Tag field layout
   localparam int TAG_FIELD_BITS = 2;

   // Command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // What the back does with one byte
   typedef enum logic [1:0] {
      CMD_TAG   = 2'd0,  // tag byte: clear accumulator, no result
      CMD_BYTE  = 2'd1,  // value byte that does not finish its value
      CMD_EMIT  = 2'd2,  // last byte of a value: merge and send
      CMD_TRUNC = 2'd3   // stream ended early: send error, clear
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [2:0]   pos;      // byte lane within the 64-bit value
   } cmd_type;

   // Number of bytes for a 2-bit size code: 1, 2, 4 or 8
   function automatic logic [3:0] size_bytes(input logic [1:0] code);
      size_bytes = 4'd1 << code;
   endfunction

endpackage

// ===== hdl/gvd_if.sv =====
// Valid/ready channel interfaces for the group varint decoder:
// the byte input channel and the decoded value result channel.
// No dependencies.
`timescale 1ns / 1ps

interface gvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface gvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hdl/group_varint_decoder.sv =====
// Top level of the group varint decoder: front, command queue and back.
// Depends on gvd_pkg, gvd_if, gvd_front, gvd_queue and gvd_back.
//
//   channel   dir   signals                              beat
//   req_bus   in    valid ready data_byte end_of_stream  one stream byte
//   rsp_bus   out   valid ready value[63:0] status       one value or error
//
// One byte per cycle sustained while the queue has room; the byte finishing a
// result is queued when accepted, then registered in the output register once free.
// Throughput is set by the single-byte front parser and the one-command-a-
// cycle back; the two-entry queue absorbs short output stalls.
// Synchronous active-high reset clears parse state, queue and accumulator.
// When rsp_bus stalls, tag and mid-value bytes keep draining; req_bus is held
// off only once the queue fills.
`timescale 1ns / 1ps

module group_varint_decoder
   import gvd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   gvd_req_if.sink   req_bus,
   gvd_rsp_if.source rsp_bus
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   gvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   gvd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   gvd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== hdl/gvd_front.sv =====
// Front of the group varint decoder: tracks tag, slot and byte position
// and classifies each accepted byte into a command for the back.
// Depends on gvd_pkg and gvd_req_if.
`timescale 1ns / 1ps

module gvd_front
   import gvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   gvd_req_if.sink req_bus,
   output logic    push_valid,
   output cmd_type push_cmd,
   input  logic    push_ready
);

   logic [7:0] tag_shift_ff, tag_shift_in;
   logic [1:0] slot_ff, slot_in;
   logic       in_value_ff, in_value_in;
   logic [2:0] bytes_taken_ff, bytes_taken_in;
   logic [1:0] size_code_ff, size_code_in;

   logic       accept;
   logic [3:0] taken;
   logic       done;
   logic [1:0] slot_next;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;
   assign push_valid    = req_bus.valid;

   assign taken     = {1'b0, bytes_taken_ff} + 4'd1;
   assign done      = (taken >= size_bytes(size_code_ff));
   assign slot_next = slot_ff + 2'd1;

   // Classify the byte and work out the next parse state
   always_comb begin
      tag_shift_in   = tag_shift_ff;
      slot_in        = slot_ff;
      in_value_in    = in_value_ff;
      bytes_taken_in = bytes_taken_ff;
      size_code_in   = size_code_ff;
      push_cmd.data_byte = req_bus.data_byte;
      push_cmd.pos       = bytes_taken_ff;
      push_cmd.kind      = CMD_TAG;

      if (!in_value_ff) begin
         push_cmd.kind  = req_bus.end_of_stream ? CMD_TRUNC : CMD_TAG;
         tag_shift_in   = req_bus.data_byte;
         size_code_in   = req_bus.data_byte[1:0];
         slot_in        = 2'd0;
         bytes_taken_in = 3'd0;
         in_value_in    = 1'b1;
      end else if (done) begin
         push_cmd.kind  = CMD_EMIT;
         bytes_taken_in = 3'd0;
         slot_in        = slot_next;
         tag_shift_in   = tag_shift_ff >> TAG_FIELD_BITS;
         size_code_in   = tag_shift_ff[2*TAG_FIELD_BITS-1:TAG_FIELD_BITS];
         in_value_in    = (slot_next != 2'd0);
      end else begin
         push_cmd.kind  = req_bus.end_of_stream ? CMD_TRUNC : CMD_BYTE;
         bytes_taken_in = taken[2:0];
      end

      // End of stream clears everything for the next stream
      if (req_bus.end_of_stream) begin
         tag_shift_in   = 8'd0;
         slot_in        = 2'd0;
         in_value_in    = 1'b0;
         bytes_taken_in = 3'd0;
         size_code_in   = 2'd0;
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_shift_ff   <= 8'd0;
         slot_ff        <= 2'd0;
         in_value_ff    <= 1'b0;
         bytes_taken_ff <= 3'd0;
         size_code_ff   <= 2'd0;
      end else if (accept) begin
         tag_shift_ff   <= tag_shift_in;
         slot_ff        <= slot_in;
         in_value_ff    <= in_value_in;
         bytes_taken_ff <= bytes_taken_in;
         size_code_ff   <= size_code_in;
      end
   end

endmodule

// ===== hdl/gvd_queue.sv =====
// Short command queue that decouples the decoder front from the back.
// Register-based FIFO of Q_DEPTH entries.
// Depends on gvd_pkg.
`timescale 1ns / 1ps

module gvd_queue
   import gvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, payload only
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/gvd_back.sv =====
// Back of the group varint decoder: assembles value bytes little-endian
// in the accumulator and drives the registered result channel.
// Depends on gvd_pkg and gvd_rsp_if.
`timescale 1ns / 1ps

module gvd_back
   import gvd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  cmd_type   pop_cmd,
   output logic      pop_ready,
   gvd_rsp_if.source rsp_bus
);

   logic [63:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_status_ff, rsp_status_in;

   logic        emits;
   logic        do_pop;
   logic [63:0] merged;

   assign emits  = (pop_cmd.kind == CMD_EMIT) || (pop_cmd.kind == CMD_TRUNC);
   // Commands without a result never wait on the output register
   assign pop_ready = !emits || !rsp_valid_ff || rsp_bus.ready;
   assign do_pop    = pop_valid && pop_ready;
   assign merged    = acc_ff | ({56'd0, pop_cmd.data_byte} << {pop_cmd.pos, 3'b000});

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

   // Carry out one command
   always_comb begin
      acc_in        = acc_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      if (do_pop) begin
         case (pop_cmd.kind)
            CMD_BYTE: begin
               acc_in = merged;
            end
            CMD_TAG: begin
               acc_in = 64'd0;
            end
            CMD_EMIT: begin
               acc_in        = 64'd0;
               rsp_value_in  = merged;
               rsp_status_in = STATUS_OK;
               rsp_valid_in  = 1'b1;
            end
            CMD_TRUNC: begin
               acc_in        = 64'd0;
               rsp_value_in  = 64'd0;
               rsp_status_in = STATUS_TRUNC;
               rsp_valid_in  = 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
